>>> src/rcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared constants and types for the RGB color classifier.
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int LEVEL_BITS_DEF = 12;
   localparam int RAW_W          = 15;
   localparam int REF_W          = 47;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 48;
   localparam int NUM_LEVEL_REGS = 5;
   localparam int NUM_CHAN       = 3;

   // scale applied before the divide
   localparam int SCALE          = 1000;
   localparam int SCALE_W        = 10;
   localparam int NUM_W          = RAW_W + SCALE_W;

   // margin: round(12*|t|/100) computed as (12*|t|+50)*MARGIN_K >> MARGIN_SH
   localparam int MARGIN_SH      = 26;
   localparam int MARGIN_K_W     = 20;
   localparam logic [MARGIN_K_W-1:0] MARGIN_K = 20'd671089;
   localparam int MARGIN_BASE    = 30;
   localparam int WHITE_LIMIT    = 30;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DARK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_YELLOW = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLACK  = 3'd6;

   // position of each class in the level register bank
   localparam int LV_RED    = 0;
   localparam int LV_BLUE   = 1;
   localparam int LV_GREEN  = 2;
   localparam int LV_YELLOW = 3;
   localparam int LV_BLACK  = 4;

   // channel order inside packed words
   localparam int CH_R = 0;
   localparam int CH_G = 1;
   localparam int CH_B = 2;

   // class codes
   localparam logic [2:0] CLS_RED    = 3'd0;
   localparam logic [2:0] CLS_BLUE   = 3'd1;
   localparam logic [2:0] CLS_GREEN  = 3'd2;
   localparam logic [2:0] CLS_YELLOW = 3'd3;
   localparam logic [2:0] CLS_WHITE  = 3'd4;
   localparam logic [2:0] CLS_BLACK  = 3'd5;
   localparam logic [2:0] CLS_NONE   = 3'd6;

   typedef struct packed {
      logic neg;    // quotient sign
      logic zero;   // zero denominator
      logic ovf;    // quotient at or above 2^L
   } div_flags_type;

endpackage

>>> src/rgb_color_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_classifier
// Normalizes raw RGB pulse widths against dark/white references and
// classifies the triple into one of seven color classes.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  req      req_valid / req_ready     req_raw_red, req_raw_green, req_raw_blue
//  rsp      rsp_valid / rsp_ready     rsp_color_class, rsp_norm_red/green/blue
//  csr      csr_valid / csr_ready     csr_index, csr_data
//
// One request per cycle is taken while the response side keeps up.
// Stages: three front stages (offset, x1000 scale, overflow check), one
// restoring-divide stage per quotient bit, saturation, then the class
// compare into the response register. Each stage holds its own valid bit;
// a stage moves when the next is empty or moving, so bubbles close up
// under backpressure. Reset clears valid bits and config registers.
// CSR writes are always taken; the class bounds follow a level write
// through the margin product register and then the bound registers.
// ----------------------------------------------------------------------------
module rgb_color_classifier #(
   parameter int LEVEL_BITS = rcc_pkg::LEVEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rcc_pkg::RAW_W-1:0]         req_raw_red,
   input  logic [rcc_pkg::RAW_W-1:0]         req_raw_green,
   input  logic [rcc_pkg::RAW_W-1:0]         req_raw_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_color_class,
   output logic signed [LEVEL_BITS-1:0]      rsp_norm_red,
   output logic signed [LEVEL_BITS-1:0]      rsp_norm_green,
   output logic signed [LEVEL_BITS-1:0]      rsp_norm_blue,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rcc_pkg::*;

   localparam int NS    = LEVEL_BITS + 5;   // lane stages plus class stage
   localparam int LVL_W = 3 * LEVEL_BITS;
   localparam int B_W   = LEVEL_BITS + 2;

   // ---------------- configuration ----------------
   logic [REF_W-1:0] dark_ff, white_ff;
   logic [LVL_W-1:0] lvl_ff [NUM_LEVEL_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff  <= '0;
         white_ff <= '0;
         for (int k = 0; k < NUM_LEVEL_REGS; k++) begin
            lvl_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_DARK:   dark_ff           <= csr_data[REF_W-1:0];
            REG_WHITE:  white_ff          <= csr_data[REF_W-1:0];
            REG_RED:    lvl_ff[LV_RED]    <= csr_data[LVL_W-1:0];
            REG_BLUE:   lvl_ff[LV_BLUE]   <= csr_data[LVL_W-1:0];
            REG_GREEN:  lvl_ff[LV_GREEN]  <= csr_data[LVL_W-1:0];
            REG_YELLOW: lvl_ff[LV_YELLOW] <= csr_data[LVL_W-1:0];
            REG_BLACK:  lvl_ff[LV_BLACK]  <= csr_data[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      for (int i = 0; i < NS; i++) begin
         if (adv[i]) begin
            valid_in[i] = (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NS-1];

   // ---------------- channel lanes ----------------
   logic [RAW_W-1:0] raw_v [NUM_CHAN];
   logic signed [LEVEL_BITS-1:0] norm_v [NUM_CHAN];

   assign raw_v[CH_R] = req_raw_red;
   assign raw_v[CH_G] = req_raw_green;
   assign raw_v[CH_B] = req_raw_blue;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
      rcc_lane #(
         .LEVEL_BITS (LEVEL_BITS)
      ) u_lane (
         .clock (clock),
         .en    (adv[NS-2:0]),
         .raw   (raw_v[c]),
         .dark  (dark_ff[16*c +: RAW_W]),
         .white (white_ff[16*c +: RAW_W]),
         .norm  (norm_v[c])
      );
   end

   // ---------------- class bounds ----------------
   logic signed [B_W-1:0] lo_b [NUM_LEVEL_REGS][NUM_CHAN];
   logic signed [B_W-1:0] hi_b [NUM_LEVEL_REGS][NUM_CHAN];

   for (genvar k = 0; k < NUM_LEVEL_REGS; k++) begin : g_lvl
      for (genvar c = 0; c < NUM_CHAN; c++) begin : g_ch
         rcc_bounds #(
            .LEVEL_BITS (LEVEL_BITS)
         ) u_bounds (
            .clock    (clock),
            .level    (lvl_ff[k][LEVEL_BITS*c +: LEVEL_BITS]),
            .lo_bound (lo_b[k][c]),
            .hi_bound (hi_b[k][c])
         );
      end
   end

   // ---------------- classification / response register ----------------
   rcc_classify #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_classify (
      .clock       (clock),
      .en          (adv[NS-1]),
      .r           (norm_v[CH_R]),
      .g           (norm_v[CH_G]),
      .b           (norm_v[CH_B]),
      .lo_b        (lo_b),
      .hi_b        (hi_b),
      .color_class (rsp_color_class),
      .norm_red    (rsp_norm_red),
      .norm_green  (rsp_norm_green),
      .norm_blue   (rsp_norm_blue)
   );

endmodule

>>> src/rcc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_div_step
// One registered restoring-division step producing quotient bit BIT.
// ----------------------------------------------------------------------------
module rcc_div_step #(
   parameter int LEVEL_BITS = rcc_pkg::LEVEL_BITS_DEF,
   parameter int BIT        = 0
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [rcc_pkg::RAW_W+LEVEL_BITS:0]  rem_i,
   input  logic [rcc_pkg::RAW_W-1:0]           den_i,
   input  logic [LEVEL_BITS-1:0]               quo_i,
   input  rcc_pkg::div_flags_type              flg_i,
   output logic [rcc_pkg::RAW_W+LEVEL_BITS:0]  rem_o,
   output logic [rcc_pkg::RAW_W-1:0]           den_o,
   output logic [LEVEL_BITS-1:0]               quo_o,
   output rcc_pkg::div_flags_type              flg_o
);
   import rcc_pkg::*;

   localparam int CMP_W = RAW_W + LEVEL_BITS + 1;

   logic [CMP_W-1:0]      sub;
   logic                  ge;
   logic [CMP_W-1:0]      rem_in, rem_ff;
   logic [LEVEL_BITS-1:0] quo_in, quo_ff;
   logic [RAW_W-1:0]      den_ff;
   div_flags_type         flg_ff;

   always_comb begin
      sub    = {{(CMP_W-RAW_W){1'b0}}, den_i} << BIT;
      ge     = rem_i >= sub;
      rem_in = ge ? rem_i - sub : rem_i;
      quo_in = quo_i;
      quo_in[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= den_i;
         flg_ff <= flg_i;
      end
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign den_o = den_ff;
   assign flg_o = flg_ff;

endmodule

>>> src/rcc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_lane
// One channel: offset, scale, pipelined divide and saturation.
// ----------------------------------------------------------------------------
module rcc_lane #(
   parameter int LEVEL_BITS = rcc_pkg::LEVEL_BITS_DEF
) (
   input  logic                           clock,
   input  logic [LEVEL_BITS+3:0]          en,
   input  logic [rcc_pkg::RAW_W-1:0]      raw,
   input  logic [rcc_pkg::RAW_W-1:0]      dark,
   input  logic [rcc_pkg::RAW_W-1:0]      white,
   output logic signed [LEVEL_BITS-1:0]   norm
);
   import rcc_pkg::*;

   localparam int CMP_W = RAW_W + LEVEL_BITS + 1;
   localparam logic [LEVEL_BITS-1:0] HALF = {1'b1, {(LEVEL_BITS-1){1'b0}}};
   localparam logic [LEVEL_BITS-1:0] HI   = {1'b0, {(LEVEL_BITS-1){1'b1}}};

   // stage 0: differences
   logic [RAW_W:0]   diff, den;
   logic [RAW_W-1:0] adiff_in, aden_in, adiff_ff, aden0_ff;
   div_flags_type    flg_in, flg0_ff;

   always_comb begin
      diff     = {1'b0, raw} - {1'b0, white};
      den      = {1'b0, dark} - {1'b0, white};
      adiff_in = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
      aden_in  = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];
      flg_in.neg  = diff[RAW_W] ^ den[RAW_W];
      flg_in.zero = (den == '0);
      flg_in.ovf  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         adiff_ff <= adiff_in;
         aden0_ff <= aden_in;
         flg0_ff  <= flg_in;
      end
   end

   // stage 1: scale by 1000
   logic [NUM_W-1:0] num_ff;
   logic [RAW_W-1:0] aden1_ff;
   div_flags_type    flg1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         num_ff   <= adiff_ff * SCALE_W'(SCALE);
         aden1_ff <= aden0_ff;
         flg1_ff  <= flg0_ff;
      end
   end

   // stage 2: overflow check against den << L
   logic [CMP_W-1:0] num_x, lim;
   div_flags_type    flg2_in;
   logic [CMP_W-1:0]      rem_c [0:LEVEL_BITS];
   logic [RAW_W-1:0]      den_c [0:LEVEL_BITS];
   logic [LEVEL_BITS-1:0] quo_c [0:LEVEL_BITS];
   div_flags_type         flg_c [0:LEVEL_BITS];

   always_comb begin
      num_x   = {{(CMP_W-NUM_W){1'b0}}, num_ff};
      lim     = {{(CMP_W-RAW_W){1'b0}}, aden1_ff} << LEVEL_BITS;
      flg2_in = flg1_ff;
      flg2_in.ovf = num_x >= lim;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rem_c[0] <= num_x;
         den_c[0] <= aden1_ff;
         quo_c[0] <= '0;
         flg_c[0] <= flg2_in;
      end
   end

   // divide steps, most significant quotient bit first
   for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_step
      rcc_div_step #(
         .LEVEL_BITS (LEVEL_BITS),
         .BIT        (LEVEL_BITS - 1 - j)
      ) u_step (
         .clock (clock),
         .en    (en[3+j]),
         .rem_i (rem_c[j]),
         .den_i (den_c[j]),
         .quo_i (quo_c[j]),
         .flg_i (flg_c[j]),
         .rem_o (rem_c[j+1]),
         .den_o (den_c[j+1]),
         .quo_o (quo_c[j+1]),
         .flg_o (flg_c[j+1])
      );
   end

   // final stage: sign and saturation
   logic [LEVEL_BITS-1:0] q;
   div_flags_type         f;
   logic [LEVEL_BITS-1:0] norm_in, norm_ff;

   always_comb begin
      q = quo_c[LEVEL_BITS];
      f = flg_c[LEVEL_BITS];
      if (f.zero) begin
         norm_in = '0;
      end else if (!f.neg) begin
         norm_in = (f.ovf || q[LEVEL_BITS-1]) ? HI : q;
      end else begin
         norm_in = (f.ovf || q > HALF) ? HALF : LEVEL_BITS'(-q);
      end
   end

   always_ff @(posedge clock) begin
      if (en[LEVEL_BITS+3]) begin
         norm_ff <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

>>> src/rcc_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_bounds
// Widened lower and upper bounds t -/+ margin(t) for one class level.
// ----------------------------------------------------------------------------
module rcc_bounds #(
   parameter int LEVEL_BITS = rcc_pkg::LEVEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic [LEVEL_BITS-1:0]         level,
   output logic signed [LEVEL_BITS+1:0]  lo_bound,
   output logic signed [LEVEL_BITS+1:0]  hi_bound
);
   import rcc_pkg::*;

   localparam int X_W = LEVEL_BITS + 4;
   localparam int P_W = X_W + MARGIN_K_W;
   localparam int B_W = LEVEL_BITS + 2;

   logic [LEVEL_BITS-1:0] abs_t;
   logic [X_W-1:0]        x;
   logic [P_W-1:0]        prod_ff;
   logic [LEVEL_BITS-1:0] lvl_ff;
   logic [B_W-1:0]        mag, m, t_x, lo_in, hi_in, lo_ff, hi_ff;

   always_comb begin
      abs_t = level[LEVEL_BITS-1] ? LEVEL_BITS'(-level) : level;
      x     = X_W'(abs_t) * X_W'(12) + X_W'(50);
   end

   always_ff @(posedge clock) begin
      prod_ff <= P_W'(x) * P_W'(MARGIN_K);
      lvl_ff  <= level;
   end

   always_comb begin
      mag   = B_W'(prod_ff >> MARGIN_SH);
      m     = (lvl_ff[LEVEL_BITS-1] ? B_W'(-mag) : mag) + B_W'(MARGIN_BASE);
      t_x   = {{2{lvl_ff[LEVEL_BITS-1]}}, lvl_ff};
      lo_in = t_x - m;
      hi_in = t_x + m;
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign lo_bound = lo_ff;
   assign hi_bound = hi_ff;

endmodule

>>> src/rcc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_classify
// Priority class tests on the normalized triple, registered result.
// ----------------------------------------------------------------------------
module rcc_classify #(
   parameter int LEVEL_BITS = rcc_pkg::LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [LEVEL_BITS-1:0] r,
   input  logic signed [LEVEL_BITS-1:0] g,
   input  logic signed [LEVEL_BITS-1:0] b,
   input  logic signed [LEVEL_BITS+1:0] lo_b [rcc_pkg::NUM_LEVEL_REGS][rcc_pkg::NUM_CHAN],
   input  logic signed [LEVEL_BITS+1:0] hi_b [rcc_pkg::NUM_LEVEL_REGS][rcc_pkg::NUM_CHAN],
   output logic [2:0]                   color_class,
   output logic signed [LEVEL_BITS-1:0] norm_red,
   output logic signed [LEVEL_BITS-1:0] norm_green,
   output logic signed [LEVEL_BITS-1:0] norm_blue
);
   import rcc_pkg::*;

   localparam int B_W = LEVEL_BITS + 2;

   logic signed [B_W-1:0] xv [NUM_CHAN];
   logic ab [NUM_LEVEL_REGS][NUM_CHAN];
   logic be [NUM_LEVEL_REGS][NUM_CHAN];
   logic [2:0] cls_in, cls_ff;
   logic signed [LEVEL_BITS-1:0] r_ff, g_ff, b_ff;

   always_comb begin
      xv[CH_R] = B_W'(r);
      xv[CH_G] = B_W'(g);
      xv[CH_B] = B_W'(b);
      for (int k = 0; k < NUM_LEVEL_REGS; k++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            ab[k][c] = xv[c] > lo_b[k][c];
            be[k][c] = xv[c] < hi_b[k][c];
         end
      end

      if (ab[LV_RED][CH_B] && ab[LV_RED][CH_G] && be[LV_RED][CH_R]) begin
         cls_in = CLS_RED;
      end else if (be[LV_BLUE][CH_B] && ab[LV_BLUE][CH_G] && ab[LV_BLUE][CH_R]) begin
         cls_in = CLS_BLUE;
      end else if (ab[LV_GREEN][CH_B] && be[LV_GREEN][CH_G] && ab[LV_GREEN][CH_R]) begin
         cls_in = CLS_GREEN;
      end else if (ab[LV_YELLOW][CH_B] && be[LV_YELLOW][CH_G]
                   && be[LV_YELLOW][CH_R]) begin
         cls_in = CLS_YELLOW;
      end else if (xv[CH_R] < B_W'(WHITE_LIMIT) && xv[CH_G] < B_W'(WHITE_LIMIT)
                   && xv[CH_B] < B_W'(WHITE_LIMIT)) begin
         cls_in = CLS_WHITE;
      end else if (ab[LV_BLACK][CH_R] && ab[LV_BLACK][CH_G] && ab[LV_BLACK][CH_B]) begin
         cls_in = CLS_BLACK;
      end else begin
         cls_in = CLS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff <= cls_in;
         r_ff   <= r;
         g_ff   <= g;
         b_ff   <= b;
      end
   end

   assign color_class = cls_ff;
   assign norm_red    = r_ff;
   assign norm_green  = g_ff;
   assign norm_blue   = b_ff;

endmodule

>>> tb/sv/rcc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_scoreboard
// Watches the csr, request and response channels of the color classifier.
// It keeps a shadow of the registers, predicts every response, and compares
// each response in order, field by field.
// ----------------------------------------------------------------------------
module rcc_scoreboard (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [rcc_pkg::RAW_W-1:0]           req_raw_red,
   input  logic [rcc_pkg::RAW_W-1:0]           req_raw_green,
   input  logic [rcc_pkg::RAW_W-1:0]           req_raw_blue,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [2:0]                          rsp_color_class,
   input  logic [rcc_pkg::LEVEL_BITS_DEF-1:0]  rsp_norm_red,
   input  logic [rcc_pkg::LEVEL_BITS_DEF-1:0]  rsp_norm_green,
   input  logic [rcc_pkg::LEVEL_BITS_DEF-1:0]  rsp_norm_blue,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcc_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  fail_count,
   output int                                  pending
);
   import rcc_pkg::*;

   localparam int L = LEVEL_BITS_DEF;

   typedef struct {
      logic [2:0]   cls;
      logic [L-1:0] nr;
      logic [L-1:0] ng;
      logic [L-1:0] nb;
   } color_result_type;

   logic [REF_W-1:0] dark_ref;
   logic [REF_W-1:0] white_ref;
   logic [3*L-1:0]   class_lv [NUM_LEVEL_REGS];
   color_result_type result_q [$];

   function automatic longint level_at(int cls_pos, int ch);
      logic signed [L-1:0] t;
      t = class_lv[cls_pos][L*ch +: L];
      return longint'(t);
   endfunction

   function automatic longint widen(longint t);
      longint q;
      if (t >= 0) q = (12 * t + 50) / 100;
      else q = -((-12 * t + 50) / 100);
      return q + MARGIN_BASE;
   endfunction

   function automatic bit over_lv(longint x, int cls_pos, int ch);
      longint t;
      t = level_at(cls_pos, ch);
      return x > t - widen(t);
   endfunction

   function automatic bit under_lv(longint x, int cls_pos, int ch);
      longint t;
      t = level_at(cls_pos, ch);
      return x < t + widen(t);
   endfunction

   function automatic longint norm_chan(logic [RAW_W-1:0] raw, int ch);
      longint w, d, den, v, hi;
      w   = longint'(white_ref[16*ch +: RAW_W]);
      d   = longint'(dark_ref[16*ch +: RAW_W]);
      den = d - w;
      hi  = (longint'(1) <<< (L - 1)) - 1;
      if (den == 0) return 0;
      v = (longint'(raw) - w) * SCALE / den;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v;
   endfunction

   function automatic color_result_type classify(logic [RAW_W-1:0] rr,
                                                 logic [RAW_W-1:0] rg,
                                                 logic [RAW_W-1:0] rb);
      color_result_type res;
      longint r, g, b;
      r = norm_chan(rr, CH_R);
      g = norm_chan(rg, CH_G);
      b = norm_chan(rb, CH_B);
      if (over_lv(b, LV_RED, CH_B) && over_lv(g, LV_RED, CH_G) && under_lv(r, LV_RED, CH_R))
         res.cls = CLS_RED;
      else if (under_lv(b, LV_BLUE, CH_B) && over_lv(g, LV_BLUE, CH_G)
               && over_lv(r, LV_BLUE, CH_R))
         res.cls = CLS_BLUE;
      else if (over_lv(b, LV_GREEN, CH_B) && under_lv(g, LV_GREEN, CH_G)
               && over_lv(r, LV_GREEN, CH_R))
         res.cls = CLS_GREEN;
      else if (over_lv(b, LV_YELLOW, CH_B) && under_lv(g, LV_YELLOW, CH_G)
               && under_lv(r, LV_YELLOW, CH_R))
         res.cls = CLS_YELLOW;
      else if (r < WHITE_LIMIT && g < WHITE_LIMIT && b < WHITE_LIMIT)
         res.cls = CLS_WHITE;
      else if (over_lv(r, LV_BLACK, CH_R) && over_lv(g, LV_BLACK, CH_G)
               && over_lv(b, LV_BLACK, CH_B))
         res.cls = CLS_BLACK;
      else
         res.cls = CLS_NONE;
      res.nr = r[L-1:0];
      res.ng = g[L-1:0];
      res.nb = b[L-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      color_result_type want;
      if (reset) begin
         dark_ref   = '0;
         white_ref  = '0;
         foreach (class_lv[i]) class_lv[i] = '0;
         result_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $error("response with nothing expected: class %0d", rsp_color_class);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_color_class !== want.cls) begin
                  $error("color_class expected %0d actual %0d", want.cls, rsp_color_class);
                  fail_count++;
               end
               if (rsp_norm_red !== want.nr) begin
                  $error("norm_red expected %0d actual %0d",
                         $signed(want.nr), $signed(rsp_norm_red));
                  fail_count++;
               end
               if (rsp_norm_green !== want.ng) begin
                  $error("norm_green expected %0d actual %0d",
                         $signed(want.ng), $signed(rsp_norm_green));
                  fail_count++;
               end
               if (rsp_norm_blue !== want.nb) begin
                  $error("norm_blue expected %0d actual %0d",
                         $signed(want.nb), $signed(rsp_norm_blue));
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            result_q.push_back(classify(req_raw_red, req_raw_green, req_raw_blue));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DARK:   dark_ref  = csr_data[REF_W-1:0];
               REG_WHITE:  white_ref = csr_data[REF_W-1:0];
               REG_RED:    class_lv[LV_RED]    = csr_data[3*L-1:0];
               REG_BLUE:   class_lv[LV_BLUE]   = csr_data[3*L-1:0];
               REG_GREEN:  class_lv[LV_GREEN]  = csr_data[3*L-1:0];
               REG_YELLOW: class_lv[LV_YELLOW] = csr_data[3*L-1:0];
               REG_BLACK:  class_lv[LV_BLACK]  = csr_data[3*L-1:0];
               default: ;
            endcase
         end
      end
      pending = result_q.size();
   end

endmodule

>>> tb/sv/rgb_color_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_classifier_tb
// Drives requests and register writes into the color classifier in phases,
// each with its own references and class levels, under random idle bursts
// on both channels. The scoreboard predicts and checks every response.
// ----------------------------------------------------------------------------
module rgb_color_classifier_tb;
   import rcc_pkg::*;

   localparam int L          = LEVEL_BITS_DEF;
   localparam int DRAIN      = L + 5 + 8;     // pipeline depth plus slack
   localparam int CYCLE_CAP  = 400000;
   localparam int NUM_PHASES = 7;
   localparam int PHASE_REQS = 65;
   // index with no register behind it: the write must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [RAW_W-1:0]      req_raw_red = '0;
   logic [RAW_W-1:0]      req_raw_green = '0;
   logic [RAW_W-1:0]      req_raw_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_color_class;
   logic [L-1:0]          rsp_norm_red;
   logic [L-1:0]          rsp_norm_green;
   logic [L-1:0]          rsp_norm_blue;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int  fail_count;
   int  pending;
   int  cycles = 0;
   bit  idle_on = 1'b1;        // cleared for the last phase
   int  sink_stall = 0;

   // per-phase raw window, used to keep most requests in the useful range
   logic [RAW_W-1:0] win_lo [NUM_CHAN];
   logic [RAW_W-1:0] win_hi [NUM_CHAN];

   initial begin
      forever #2 clock = ~clock;
   end

   rgb_color_classifier dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_raw_red, .req_raw_green, .req_raw_blue,
      .rsp_valid, .rsp_ready, .rsp_color_class,
      .rsp_norm_red, .rsp_norm_green, .rsp_norm_blue,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   rcc_scoreboard chk (
      .clock, .reset,
      .req_valid, .req_ready, .req_raw_red, .req_raw_green, .req_raw_blue,
      .rsp_valid, .rsp_ready, .rsp_color_class,
      .rsp_norm_red, .rsp_norm_green, .rsp_norm_blue,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: ready with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         sink_stall <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   task automatic send_req(logic [RAW_W-1:0] r, logic [RAW_W-1:0] g, logic [RAW_W-1:0] b);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_red   <= r;
      req_raw_green <= g;
      req_raw_blue  <= b;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // nothing outstanding, then let the pipeline empty out
   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [L-1:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(L-1){1'b0}}};     // most negative
         1:       return {1'b0, {(L-1){1'b1}}};     // most positive
         2, 3:    return L'($urandom);
         default: return L'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] level_word();
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'({$urandom, $urandom});    // junk above the register width
      w[3*L-1:0] = {pick_level(), pick_level(), pick_level()};
      return w;
   endfunction

   // random dark/white pair for one channel, with the window between them
   task automatic pick_refs(int ch, output logic [RAW_W-1:0] dk, output logic [RAW_W-1:0] wt);
      case ($urandom_range(0, 9))
         0: begin dk = RAW_W'($urandom_range(0, 32767)); wt = dk; end      // equal refs
         1: begin
            wt = RAW_W'($urandom_range(2000, 32767));
            dk = RAW_W'($urandom_range(0, 1999));
         end
         2: begin dk = 15'h7fff; wt = 15'h0000; end
         3: begin dk = 15'h0000; wt = 15'h7fff; end
         4: begin
            wt = RAW_W'($urandom_range(0, 100));
            dk = wt + RAW_W'($urandom_range(1, 40));
         end
         default: begin
            wt = RAW_W'($urandom_range(0, 3000));
            dk = wt + RAW_W'($urandom_range(200, 20000));
         end
      endcase
      win_lo[ch] = (dk < wt) ? dk : wt;
      win_hi[ch] = (dk < wt) ? wt : dk;
   endtask

   task automatic load_random_setup();
      logic [CSR_DATA_W-1:0] dw, ww;
      logic [RAW_W-1:0] dk, wt;
      dw = CSR_DATA_W'({$urandom, $urandom});
      ww = CSR_DATA_W'({$urandom, $urandom});
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         pick_refs(ch, dk, wt);
         dw[16*ch +: RAW_W] = dk;
         ww[16*ch +: RAW_W] = wt;
      end
      csr_write(REG_DARK, dw);
      csr_write(REG_WHITE, ww);
      csr_write(REG_RED, level_word());
      csr_write(REG_BLUE, level_word());
      csr_write(REG_GREEN, level_word());
      csr_write(REG_YELLOW, level_word());
      csr_write(REG_BLACK, level_word());
      if ($urandom_range(0, 1)) csr_write(REG_NONE, CSR_DATA_W'({$urandom, $urandom}));
      csr_valid <= 1'b0;
      repeat (4) @(posedge clock);   // let the level bounds settle after the last write
   endtask

   function automatic logic [RAW_W-1:0] pick_raw(int ch);
      if ($urandom_range(0, 4) == 0) return RAW_W'($urandom);
      return RAW_W'($urandom_range(win_lo[ch], win_hi[ch]));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] dw, ww;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero registers: every channel has equal references
      send_req(15'h0000, 15'h0000, 15'h0000);
      send_req(15'h7fff, 15'h7fff, 15'h7fff);
      send_req(15'h5555, 15'h2aaa, 15'h7fff);
      req_valid <= 1'b0;
      wait_idle();

      // directed: red full span, green equal refs, blue reversed and narrow
      dw = '1;
      ww = '1;
      dw[16*CH_R +: RAW_W] = 15'h7fff;  ww[16*CH_R +: RAW_W] = 15'h0000;
      dw[16*CH_G +: RAW_W] = 15'd100;   ww[16*CH_G +: RAW_W] = 15'd100;
      dw[16*CH_B +: RAW_W] = 15'd5;     ww[16*CH_B +: RAW_W] = 15'd10;
      csr_write(REG_DARK, dw);
      csr_write(REG_WHITE, ww);
      csr_write(REG_RED, {12'd0, 12'h800, 12'h7ff, 12'h800});
      csr_write(REG_BLUE, {12'd0, 12'd500, 12'd500, 12'd500});
      csr_write(REG_GREEN, {12'hfff, 12'h7ff, 12'h800, 12'h7ff});
      csr_write(REG_YELLOW, {12'd0, 12'd200, 12'd800, 12'd300});
      csr_write(REG_BLACK, {12'h000, 12'h800, 12'h800, 12'h800});
      csr_write(REG_NONE, '1);
      csr_valid <= 1'b0;
      repeat (4) @(posedge clock);
      send_req(15'h0000, 15'h0000, 15'h0000);   // blue near the positive limit
      send_req(15'h7fff, 15'h7fff, 15'h7fff);   // blue saturates low
      send_req(15'h7fff, 15'h0000, 15'd10);
      send_req(15'h0000, 15'h7fff, 15'd5);
      send_req(15'd983, 15'd100, 15'd7);
      send_req(15'd32, 15'd1, 15'd9);
      send_req(15'h2aaa, 15'h5555, 15'h2aaa);
      send_req(15'h5555, 15'h2aaa, 15'h5555);
      send_req(15'd16383, 15'd16384, 15'd11);
      send_req(15'd1, 15'd32766, 15'd4);
      req_valid <= 1'b0;
      wait_idle();

      // random phases, the last one with no idling on either side
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_random_setup();
         if (ph == NUM_PHASES - 1) idle_on = 1'b0;
         for (int n = 0; n < PHASE_REQS; n++)
            send_req(pick_raw(CH_R), pick_raw(CH_G), pick_raw(CH_B));
         req_valid <= 1'b0;
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
